@@ hw/rtl/spo_pkg.sv @@
package spo_pkg;

	// field widths at the ports
	localparam int FIELD_POS_W  = 32;
	localparam int FIELD_SIZE_W = 31;

	// coordinate width; positions use the low POS_W bits, sizes one bit less
	localparam int COORD_BITS = 32;
	localparam int POS_W      = (COORD_BITS > FIELD_POS_W) ? FIELD_POS_W : COORD_BITS;
	localparam int SIZE_W     = POS_W - 1;

	// pipeline depth from word accept to result strobe
	localparam int PIPE_LAT = 6;

	// test codes
	localparam logic [2:0] CMD_CIRC_CIRC = 3'd0;
	localparam logic [2:0] CMD_CIRC_BOX  = 3'd1;
	localparam logic [2:0] CMD_BOX_BOX   = 3'd2;
	localparam logic [2:0] CMD_PT_CIRC   = 3'd3;
	localparam logic [2:0] CMD_PT_BOX    = 3'd4;

	// control that travels with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic bad;
		logic is_box;
		logic is_clamp;
		logic box_hit;
	} ctl_t;

endpackage

@@ hw/rtl/spo_geom.sv @@
module spo_geom (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [2:0]                      cmd,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  a_x,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  a_y,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] a_size_x,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] a_size_y,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  b_x,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  b_y,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] b_size_x,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] b_size_y,
	output spo_pkg::ctl_t                   ctl_s3,
	output logic [spo_pkg::POS_W-1:0]       mag_x_s3,
	output logic [spo_pkg::POS_W-1:0]       mag_y_s3,
	output logic [spo_pkg::POS_W-1:0]       rad_s3
);
	import spo_pkg::*;

	localparam int DW = POS_W + 1;  // difference of two positions
	localparam int EW = POS_W + 2;  // difference plus or minus a half extent

	logic [POS_W-1:0]  ax, ay, bx, by;
	logic [SIZE_W-1:0] asx, asy, bsx, bsy;
	logic [POS_W-1:0]  sum_x, sum_y;
	logic [DW-1:0]     dx_c, dy_c;
	ctl_t              ctl_c;
	logic [POS_W-1:0]  hx_c, hy_c, rad_c;

	ctl_t              ctl_s1, ctl_s2;
	ctl_t              ctl_hit_c;
	logic [DW-1:0]     dx_s1, dy_s1, dx_s2, dy_s2;
	logic [POS_W-1:0]  hx_s1, hy_s1, rad_s1, rad_s2;
	logic [EW-1:0]     lo_x_c, hi_x_c, lo_y_c, hi_y_c;
	logic [EW-1:0]     lo_x_s2, hi_x_s2, lo_y_s2, hi_y_s2;

	logic              lo_x_pos, lo_y_pos, hi_x_pos, hi_y_pos;
	logic              box_hit_c;
	logic [EW-1:0]     del_x_c, del_y_c, abs_x_c, abs_y_c;

	// trim the fields to the coordinate width
	assign ax  = a_x[POS_W-1:0];
	assign ay  = a_y[POS_W-1:0];
	assign bx  = b_x[POS_W-1:0];
	assign by  = b_y[POS_W-1:0];
	assign asx = a_size_x[SIZE_W-1:0];
	assign asy = a_size_y[SIZE_W-1:0];
	assign bsx = b_size_x[SIZE_W-1:0];
	assign bsy = b_size_y[SIZE_W-1:0];

	// stage 1: center offsets and size sums
	assign dx_c  = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
	assign dy_c  = {ay[POS_W-1], ay} - {by[POS_W-1], by};
	assign sum_x = {1'b0, asx} + {1'b0, bsx};
	assign sum_y = {1'b0, asy} + {1'b0, bsy};

	// stage 1: test decode, picks half extents and radius
	always_comb begin
		ctl_c         = '0;
		ctl_c.valid   = in_valid;
		hx_c          = {1'b0, bsx};
		hy_c          = {1'b0, bsy};
		rad_c         = {1'b0, bsx};
		unique case (cmd)
			CMD_CIRC_CIRC: begin
				rad_c = sum_x;
			end
			CMD_CIRC_BOX: begin
				ctl_c.is_clamp = 1'b1;
				rad_c          = {1'b0, asx};
			end
			CMD_BOX_BOX: begin
				ctl_c.is_box = 1'b1;
				hx_c         = sum_x;
				hy_c         = sum_y;
			end
			CMD_PT_CIRC: begin
				rad_c = {1'b0, bsx};
			end
			CMD_PT_BOX: begin
				ctl_c.is_box = 1'b1;
			end
			default: begin
				ctl_c.bad = 1'b1;
			end
		endcase
	end

	// stage 2: offset against both box edges per axis
	assign lo_x_c = {dx_s1[DW-1], dx_s1} + {2'b00, hx_s1};
	assign hi_x_c = {dx_s1[DW-1], dx_s1} - {2'b00, hx_s1};
	assign lo_y_c = {dy_s1[DW-1], dy_s1} + {2'b00, hy_s1};
	assign hi_y_c = {dy_s1[DW-1], dy_s1} - {2'b00, hy_s1};

	// stage 3: strict box containment and clamped offset
	assign lo_x_pos  = !lo_x_s2[EW-1] && (|lo_x_s2);
	assign lo_y_pos  = !lo_y_s2[EW-1] && (|lo_y_s2);
	assign hi_x_pos  = !hi_x_s2[EW-1] && (|hi_x_s2);
	assign hi_y_pos  = !hi_y_s2[EW-1] && (|hi_y_s2);
	assign box_hit_c = lo_x_pos && hi_x_s2[EW-1] && lo_y_pos && hi_y_s2[EW-1];

	always_comb begin
		del_x_c = {dx_s2[DW-1], dx_s2};
		del_y_c = {dy_s2[DW-1], dy_s2};
		if (ctl_s2.is_clamp) begin
			if (lo_x_s2[EW-1]) begin
				del_x_c = lo_x_s2;
			end else if (hi_x_pos) begin
				del_x_c = hi_x_s2;
			end else begin
				del_x_c = '0;
			end
			if (lo_y_s2[EW-1]) begin
				del_y_c = lo_y_s2;
			end else if (hi_y_pos) begin
				del_y_c = hi_y_s2;
			end else begin
				del_y_c = '0;
			end
		end
	end

	assign abs_x_c = del_x_c[EW-1] ? (~del_x_c + 1'b1) : del_x_c;
	assign abs_y_c = del_y_c[EW-1] ? (~del_y_c + 1'b1) : del_y_c;

	// stage 3 control with the box verdict filled in
	always_comb begin
		ctl_hit_c         = ctl_s2;
		ctl_hit_c.box_hit = box_hit_c;
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_hit_c;
		end
	end

	// data pipeline
	always_ff @(posedge clk) begin
		dx_s1    <= dx_c;
		dy_s1    <= dy_c;
		hx_s1    <= hx_c;
		hy_s1    <= hy_c;
		rad_s1   <= rad_c;
		dx_s2    <= dx_s1;
		dy_s2    <= dy_s1;
		lo_x_s2  <= lo_x_c;
		hi_x_s2  <= hi_x_c;
		lo_y_s2  <= lo_y_c;
		hi_y_s2  <= hi_y_c;
		rad_s2   <= rad_s1;
		mag_x_s3 <= abs_x_c[POS_W-1:0];
		mag_y_s3 <= abs_y_c[POS_W-1:0];
		rad_s3   <= rad_s2;
	end

endmodule

@@ hw/rtl/spo_dist.sv @@
module spo_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spo_pkg::ctl_t               ctl_s3,
	input  logic [spo_pkg::POS_W-1:0]   mag_x_s3,
	input  logic [spo_pkg::POS_W-1:0]   mag_y_s3,
	input  logic [spo_pkg::POS_W-1:0]   rad_s3,
	output spo_pkg::ctl_t               ctl_s5,
	output logic [2*spo_pkg::POS_W:0]   dist2_s5,
	output logic [2*spo_pkg::POS_W-1:0] rad2_s5
);
	import spo_pkg::*;

	localparam int PW = 2 * POS_W;

	ctl_t          ctl_s4;
	logic [PW-1:0] sq_x_s4, sq_y_s4, rad2_s4;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// stage 4: exact squares; stage 5: squared distance
	always_ff @(posedge clk) begin
		sq_x_s4  <= {{POS_W{1'b0}}, mag_x_s3} * {{POS_W{1'b0}}, mag_x_s3};
		sq_y_s4  <= {{POS_W{1'b0}}, mag_y_s3} * {{POS_W{1'b0}}, mag_y_s3};
		rad2_s4  <= {{POS_W{1'b0}}, rad_s3} * {{POS_W{1'b0}}, rad_s3};
		dist2_s5 <= {1'b0, sq_x_s4} + {1'b0, sq_y_s4};
		rad2_s5  <= rad2_s4;
	end

endmodule

@@ hw/rtl/shape_pair_overlap_test_top.sv @@
// Strict overlap test for one pair of 2D shapes (circle, box or point) per word.
// Command channel: a word is taken at a rising edge with start high and busy
// low. busy is always low, so a new word may be given in every cycle.
// cmd picks the test: circle-circle, circle-box, box-box, point-circle or
// point-box; in the point tests shape A is the point. Positions are Q16.16,
// sizes unsigned Q15.16; a circle uses only its x size as radius.
// Result channel: done is high for exactly one cycle per word, with overlap and
// bad_cmd valid in that cycle. Results leave in the order words came in.
// Throughput: one word per cycle, set by a six stage pipeline (offsets, edge
// tests, clamp and magnitude, three 32x32 squarers, distance sum, compare).
// Touching shapes do not overlap. Codes 5 to 7 give overlap low, bad_cmd high.
// The receiver cannot stall, so no word is ever held back.
// Reset clears every stage's valid bit; words in flight are dropped.
module shape_pair_overlap_test_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [2:0]                      cmd,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  a_x,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  a_y,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] a_size_x,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] a_size_y,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  b_x,
	input  logic [spo_pkg::FIELD_POS_W-1:0]  b_y,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] b_size_x,
	input  logic [spo_pkg::FIELD_SIZE_W-1:0] b_size_y,
	output logic                            done,
	output logic                            overlap,
	output logic                            bad_cmd
);
	import spo_pkg::*;

	ctl_t               ctl_s3, ctl_s5;
	logic [POS_W-1:0]   mag_x_s3, mag_y_s3, rad_s3;
	logic [2*POS_W:0]   dist2_s5;
	logic [2*POS_W-1:0] rad2_s5;
	logic               done_q, overlap_q, bad_cmd_q;
	logic               hit_c;

	// pipeline never stalls
	assign busy = 1'b0;

	spo_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.cmd      (cmd),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_size_x (a_size_x),
		.a_size_y (a_size_y),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_size_x (b_size_x),
		.b_size_y (b_size_y),
		.ctl_s3   (ctl_s3),
		.mag_x_s3 (mag_x_s3),
		.mag_y_s3 (mag_y_s3),
		.rad_s3   (rad_s3)
	);

	spo_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.mag_x_s3 (mag_x_s3),
		.mag_y_s3 (mag_y_s3),
		.rad_s3   (rad_s3),
		.ctl_s5   (ctl_s5),
		.dist2_s5 (dist2_s5),
		.rad2_s5  (rad2_s5)
	);

	// final compare: box tests use the edge flags, circle tests the distance
	assign hit_c = ctl_s5.is_box ? ctl_s5.box_hit : (dist2_s5 < {1'b0, rad2_s5});

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s5.valid;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		overlap_q <= hit_c && !ctl_s5.bad;
		bad_cmd_q <= ctl_s5.bad;
	end

	assign done    = done_q;
	assign overlap = overlap_q;
	assign bad_cmd = bad_cmd_q;

endmodule

@@ hw/rtl/spo_checker.sv @@
module spo_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [2:0]                      cmd,
	input logic                            done,
	input logic                            overlap,
	input logic                            bad_cmd
);
	import spo_pkg::*;

	// every accepted word gives its result after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted word produced no result");

	// no result without a word accepted the fixed latency earlier
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching word");

	// an unknown test never reports overlap
	a_bad_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_cmd) |-> !overlap)
		else $error("overlap reported for bad test code");

	// error flag follows the code of the word that caused the result
	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bad_cmd == ($past(cmd, PIPE_LAT) != CMD_CIRC_CIRC &&
			$past(cmd, PIPE_LAT) != CMD_CIRC_BOX && $past(cmd, PIPE_LAT) != CMD_BOX_BOX &&
			$past(cmd, PIPE_LAT) != CMD_PT_CIRC && $past(cmd, PIPE_LAT) != CMD_PT_BOX)))
		else $error("bad_cmd does not match test code");

endmodule

bind shape_pair_overlap_test_top spo_checker u_spo_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.cmd     (cmd),
	.done    (done),
	.overlap (overlap),
	.bad_cmd (bad_cmd)
);

@@ dv/tb_shape_pair_overlap_test_top.sv @@
`timescale 1ns / 1ps

module tb_shape_pair_overlap_test_top;
	import spo_pkg::*;

	// reserved test codes, all expected to raise bad_cmd
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	localparam logic [FIELD_POS_W-1:0]  POS_MIN  = 32'h8000_0000;
	localparam logic [FIELD_POS_W-1:0]  POS_MAX  = 32'h7FFF_FFFF;
	localparam logic [FIELD_SIZE_W-1:0] SIZE_MAX = 31'h7FFF_FFFF;
	localparam int RANDOM_WORDS = 750;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int REPORT_MAX   = 10;

	typedef logic [FIELD_POS_W-1:0]  pos_t;
	typedef logic [FIELD_SIZE_W-1:0] size_t;

	typedef struct packed {
		logic overlap;
		logic bad_cmd;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] cmd = '0;
	pos_t       a_x = '0;
	pos_t       a_y = '0;
	size_t      a_size_x = '0;
	size_t      a_size_y = '0;
	pos_t       b_x = '0;
	pos_t       b_y = '0;
	size_t      b_size_x = '0;
	size_t      b_size_y = '0;
	logic       done;
	logic       overlap;
	logic       bad_cmd;

	verdict_t verdict_q[$];
	int       errors = 0;
	int       words_sent = 0;
	int       directed_words = 0;
	int       results_seen = 0;
	int       overlaps_seen = 0;
	int       bad_seen = 0;
	bit       burst_on = 1'b0;

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	shape_pair_overlap_test_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_size_x (a_size_x),
		.a_size_y (a_size_y),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_size_x (b_size_x),
		.b_size_y (b_size_y),
		.done     (done),
		.overlap  (overlap),
		.bad_cmd  (bad_cmd)
	);

	// position field as two's complement in the coordinate width
	function automatic longint pos_value(pos_t raw);
		logic signed [POS_W-1:0] low;
		low = raw[POS_W-1:0];
		return longint'(low);
	endfunction

	// size field as unsigned, one bit narrower than a position
	function automatic longint size_value(size_t raw);
		logic [SIZE_W-1:0] low;
		low = raw[SIZE_W-1:0];
		return longint'(low);
	endfunction

	// exact squared distance strictly below squared radius
	function automatic bit inside_disc(longint dx, longint dy, longint r);
		logic [127:0] mx;
		logic [127:0] my;
		logic [127:0] mr;
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		mr = r;
		return (mx * mx + my * my) < (mr * mr);
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// expected flags for one shape pair
	function automatic verdict_t overlap_verdict(logic [2:0] c, pos_t ax_r, pos_t ay_r,
			size_t asx_r, size_t asy_r, pos_t bx_r, pos_t by_r, size_t bsx_r, size_t bsy_r);
		verdict_t v;
		longint   ax, ay, asx, asy, bx, by, bsx, bsy, cx, cy;
		ax  = pos_value(ax_r);
		ay  = pos_value(ay_r);
		asx = size_value(asx_r);
		asy = size_value(asy_r);
		bx  = pos_value(bx_r);
		by  = pos_value(by_r);
		bsx = size_value(bsx_r);
		bsy = size_value(bsy_r);
		v = '0;
		case (c)
			CMD_CIRC_CIRC: v.overlap = inside_disc(ax - bx, ay - by, asx + bsx);
			CMD_CIRC_BOX: begin
				cx = clamp_to(ax, bx - bsx, bx + bsx);
				cy = clamp_to(ay, by - bsy, by + bsy);
				v.overlap = inside_disc(ax - cx, ay - cy, asx);
			end
			CMD_BOX_BOX: v.overlap = (ax - asx < bx + bsx) && (ax + asx > bx - bsx) &&
				(ay - asy < by + bsy) && (ay + asy > by - bsy);
			CMD_PT_CIRC: v.overlap = inside_disc(bx - ax, by - ay, bsx);
			CMD_PT_BOX: v.overlap = (ax > bx - bsx) && (ax < bx + bsx) &&
				(ay > by - bsy) && (ay < by + bsy);
			default: v.bad_cmd = 1'b1;
		endcase
		return v;
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t ERROR %s", $realtime, msg);
	endfunction

	// result checking and prediction of accepted words
	always @(posedge clk) begin : scoreboard
		verdict_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (overlap === 1'b1)
					overlaps_seen++;
				if (bad_cmd === 1'b1)
					bad_seen++;
				if (verdict_q.size() == 0) begin
					flag_error("result strobe with no word pending");
				end else begin
					want = verdict_q.pop_front();
					if (overlap !== want.overlap)
						flag_error($sformatf("overlap expected %b actual %b",
							want.overlap, overlap));
					if (bad_cmd !== want.bad_cmd)
						flag_error($sformatf("bad_cmd expected %b actual %b",
							want.bad_cmd, bad_cmd));
				end
			end
			if (start && !busy) begin
				words_sent++;
				verdict_q.push_back(overlap_verdict(cmd, a_x, a_y, a_size_x, a_size_y,
					b_x, b_y, b_size_x, b_size_y));
			end
		end
	end

	// mostly short gaps, a few long, none while a burst is on
	function automatic int pick_gap();
		int r;
		if (burst_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pos_t fx(int n);
		return pos_t'(n) << 16;
	endfunction

	function automatic size_t fs(int n);
		return size_t'(n) << 16;
	endfunction

	task automatic send_word(int gap, logic [2:0] c, pos_t ax, pos_t ay, size_t asx,
			size_t asy, pos_t bx, pos_t by, size_t bsx, size_t bsy);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start    <= 1'b1;
		cmd      <= c;
		a_x      <= ax;
		a_y      <= ay;
		a_size_x <= asx;
		a_size_y <= asy;
		b_x      <= bx;
		b_y      <= by;
		b_size_x <= bsx;
		b_size_y <= bsy;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending and wait for every pending result
	task automatic drain();
		int n;
		@(negedge clk);
		start <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && verdict_q.size() != 0; n++)
			@(posedge clk);
		repeat (PIPE_LAT + 2)
			@(posedge clk);
		if (verdict_q.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", verdict_q.size()));
			verdict_q.delete();
		end
	endtask

	// one hit and one miss for each test code
	task automatic test_each_code();
		send_word(pick_gap(), CMD_CIRC_CIRC, fx(0), fx(0), fs(1), '0, fx(1), fx(1), fs(1), '0);
		send_word(pick_gap(), CMD_CIRC_CIRC, fx(0), fx(0), fs(1), '0, fx(3), fx(0), fs(1), '0);
		send_word(pick_gap(), CMD_CIRC_BOX, fx(0), fx(0), fs(2), '0, fx(2), fx(0), fs(1), fs(1));
		send_word(pick_gap(), CMD_CIRC_BOX, fx(0), fx(0), fs(2), '0, fx(4), fx(4), fs(1), fs(1));
		send_word(pick_gap(), CMD_BOX_BOX, fx(0), fx(0), fs(1), fs(1), fx(1), fx(1), fs(1),
			fs(1));
		send_word(pick_gap(), CMD_BOX_BOX, fx(0), fx(0), fs(1), fs(1), fx(3), fx(0), fs(1),
			fs(1));
		send_word(pick_gap(), CMD_PT_CIRC, fx(0), fx(0), '0, '0, fx(1), fx(0), fs(2), '0);
		send_word(pick_gap(), CMD_PT_CIRC, fx(0), fx(0), '0, '0, fx(5), fx(0), fs(2), '0);
		send_word(pick_gap(), CMD_PT_BOX, fx(0), fx(0), '0, '0, fx(1), fx(1), fs(2), fs(2));
		send_word(pick_gap(), CMD_PT_BOX, fx(0), fx(0), '0, '0, fx(3), fx(3), fs(1), fs(1));
	endtask

	// shapes that only touch must not overlap; one circle pair just past touching must
	task automatic test_touching_edges();
		send_word(pick_gap(), CMD_CIRC_CIRC, fx(0), fx(0), fs(2), '0, fx(3), fx(4), fs(3), '0);
		send_word(pick_gap(), CMD_CIRC_CIRC, fx(0), fx(0), fs(2), '0, fx(3), fx(4),
			fs(3) + size_t'(1), '0);
		send_word(pick_gap(), CMD_CIRC_BOX, fx(0), fx(0), fs(1), '0, fx(2), fx(0), fs(1), fs(1));
		send_word(pick_gap(), CMD_BOX_BOX, fx(0), fx(0), fs(1), fs(1), fx(2), fx(0), fs(1),
			fs(1));
		send_word(pick_gap(), CMD_PT_CIRC, fx(3), fx(4), '0, '0, fx(0), fx(0), fs(5), '0);
		send_word(pick_gap(), CMD_PT_BOX, fx(1), fx(0), '0, '0, fx(0), fx(0), fs(1), fs(1));
	endtask

	// reserved codes with shapes that would otherwise overlap
	task automatic test_bad_codes();
		send_word(pick_gap(), CMD_RSVD_5, fx(0), fx(0), fs(1), fs(1), fx(0), fx(0), fs(1), fs(1));
		send_word(pick_gap(), CMD_RSVD_6, fx(0), fx(0), fs(1), fs(1), fx(0), fx(0), fs(1), fs(1));
		send_word(pick_gap(), CMD_RSVD_7, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, POS_MIN,
			POS_MAX, SIZE_MAX, SIZE_MAX);
	endtask

	// full scale coordinates and sizes, zero radius, ignored size fields
	task automatic test_extremes();
		send_word(pick_gap(), CMD_CIRC_CIRC, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, POS_MAX,
			POS_MAX, SIZE_MAX, SIZE_MAX);
		send_word(pick_gap(), CMD_CIRC_CIRC, POS_MAX, POS_MIN, SIZE_MAX, '0, POS_MAX, POS_MIN,
			SIZE_MAX, '0);
		send_word(pick_gap(), CMD_CIRC_BOX, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX, POS_MIN,
			POS_MAX, SIZE_MAX, SIZE_MAX);
		send_word(pick_gap(), CMD_BOX_BOX, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, POS_MAX,
			POS_MAX, SIZE_MAX, SIZE_MAX);
		send_word(pick_gap(), CMD_CIRC_CIRC, fx(7), fx(7), '0, SIZE_MAX, fx(7), fx(7), '0,
			SIZE_MAX);
		send_word(pick_gap(), CMD_PT_CIRC, fx(0), fx(0), SIZE_MAX, SIZE_MAX, fx(0), fx(0), '0,
			SIZE_MAX);
		send_word(pick_gap(), CMD_PT_BOX, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, fx(0), fx(0),
			fs(1), fs(1));
	endtask

	// value within 2^k of base, either side, wrapping at the field width
	function automatic pos_t near_pos(pos_t base, int k);
		pos_t off;
		off = $urandom & ((32'h1 << k) - 1);
		return $urandom_range(0, 1) ? base + off : base - off;
	endfunction

	function automatic size_t rand_size(int k);
		return size_t'($urandom & ((32'h1 << k) - 1));
	endfunction

	// random pairs: mostly close shapes of matching scale, some full range noise
	task automatic test_random_pairs();
		logic [2:0] c;
		pos_t       ax, ay, bx, by;
		size_t      asx, asy, bsx, bsy;
		int         k;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 64 == 0)
				burst_on = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_WORDS / 2)
				drain();
			if ($urandom_range(0, 7) == 0)
				c = 3'($urandom_range(0, 7));
			else
				c = 3'($urandom_range(CMD_CIRC_CIRC, CMD_PT_BOX));
			ax = $urandom;
			ay = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				bx  = $urandom;
				by  = $urandom;
				asx = size_t'($urandom);
				asy = size_t'($urandom);
				bsx = size_t'($urandom);
				bsy = size_t'($urandom);
			end else begin
				k   = $urandom_range(2, 30);
				asx = rand_size(k);
				asy = rand_size(k);
				bsx = rand_size(k);
				bsy = rand_size(k);
				bx  = near_pos(ax, k + 1);
				by  = near_pos(ay, k + 1);
				// box edges meeting exactly
				if ($urandom_range(0, 7) == 0)
					bx = ax + asx + bsx;
			end
			send_word(pick_gap(), c, ax, ay, asx, asy, bx, by, bsx, bsy);
		end
		burst_on = 1'b0;
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_each_code();
		test_touching_edges();
		test_bad_codes();
		test_extremes();
		directed_words = words_sent;
		test_random_pairs();
		drain();
		$display("covered %0d words (%0d directed), %0d results checked",
			words_sent, directed_words, results_seen);
		$display("results with overlap: %0d, with bad test code: %0d, mismatches: %0d",
			overlaps_seen, bad_seen, errors);
		if (errors == 0)
			$display("tb_shape_pair_overlap_test_top: PASS");
		else
			$display("tb_shape_pair_overlap_test_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_shape_pair_overlap_test_top: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/spo_pkg.sv
hw/rtl/spo_geom.sv
hw/rtl/spo_dist.sv
hw/rtl/shape_pair_overlap_test_top.sv
hw/rtl/spo_checker.sv
dv/tb_shape_pair_overlap_test_top.sv
